[design/assert_macros.svh]
// Assertion macros used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the block clock, disabled while reset is asserted.
`define C8_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on an explicitly named clock and active-low reset.
`define C8_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`endif

[design/c8_pkg.sv]
// ----------------------------------------------------------------------------
// c8_pkg
// Types, constants and the font table shared by the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8_pkg;

	localparam int MEM_BYTES       = 4096;
	localparam int MEM_AW          = 12;
	localparam int DISP_PIXELS     = 2048;
	localparam int DISP_AW         = 11;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int FONT_BYTES      = 80;

	localparam logic [11:0] START_RESET = 12'h200;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_EXEC = 2'd1;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [4:0] {
		S_SWEEP, S_IDLE, S_LOAD, S_PIX_RD, S_PIX_LAT,
		S_F_HI, S_F_LO, S_F_OPL, S_F_VX, S_F_VY, S_EXEC,
		S_RET, S_CLS, S_SETF,
		S_D_ROW, S_D_BITS, S_D_COL, S_D_PIX,
		S_BCD0, S_BCD1, S_BCD2,
		S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_IEND,
		S_TICK, S_FIN
	} state_t;

	typedef enum logic [4:0] {
		U_SWEEP, U_IDLE, U_LOAD, U_PIX_RD, U_PIX_LAT,
		U_F_HI, U_F_LO, U_F_OPL, U_F_VX, U_F_VY, U_EXEC,
		U_RET, U_CLS, U_SETF,
		U_D_ROW, U_D_BITS, U_D_COL, U_D_PIX,
		U_BCD0, U_BCD1, U_BCD2,
		U_ST_RD, U_ST_WR, U_LD_RD, U_LD_WR, U_IEND,
		U_TICK, U_FIN
	} uop_t;

	// Follow-up work that an instruction needs after its execute cycle.
	typedef enum logic [2:0] {
		CL_DONE, CL_SETF, CL_CLS, CL_RET, CL_DRAW, CL_BCD, CL_STORE, CL_LOAD
	} cls_t;

	typedef struct packed {
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic       accept;
		logic [1:0] action;
		cls_t       cls;
		logic       row_done;
		logic       bit_set;
		logic       col_last;
		logic       idx_last;
		logic       cls_last;
		logic       sweep_last;
		logic       out_free;
	} status_t;

	// Highest pressed key.
	function automatic logic [3:0] high_key(input logic [15:0] keys);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (keys[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

[design/c8_if.sv]
// ----------------------------------------------------------------------------
// c8_req_if / c8_rsp_if
// Valid/ready channels for request and result items of the CHIP-8 core.
// ----------------------------------------------------------------------------
interface c8_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [11:0] address;
	logic [7:0]  data;
	logic [15:0] keys;
	logic [7:0]  random_byte;

	modport source (output valid, action, address, data, keys, random_byte, input ready);
	modport sink (input valid, action, address, data, keys, random_byte, output ready);
endinterface

interface c8_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] program_counter;
	logic [15:0] executed_opcode;
	logic        pixel;
	logic        redraw;
	logic        beep;
	logic        waiting_key;
	logic        unknown_opcode;

	modport source (output valid, program_counter, executed_opcode, pixel, redraw, beep,
		waiting_key, unknown_opcode, input ready);
	modport sink (input valid, program_counter, executed_opcode, pixel, redraw, beep,
		waiting_key, unknown_opcode, output ready);
endinterface

[design/c8_ram.sv]
// ----------------------------------------------------------------------------
// c8_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module c8_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/c8_ctrl.sv]
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer of the CHIP-8 core: fetch, execute and multi-cycle follow-ups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c8_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  c8_pkg::status_t sts,
	output c8_pkg::cmd_t    cmd
);
	import c8_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SWEEP: if (sts.sweep_last) state_d = S_IDLE;
			S_IDLE: begin
				if (sts.accept) begin
					case (sts.action)
						ACT_LOAD: state_d = S_LOAD;
						ACT_EXEC: state_d = S_F_HI;
						default:  state_d = S_PIX_RD;
					endcase
				end
			end
			S_LOAD:    state_d = S_FIN;
			S_PIX_RD:  state_d = S_PIX_LAT;
			S_PIX_LAT: state_d = S_FIN;
			S_F_HI:    state_d = S_F_LO;
			S_F_LO:    state_d = S_F_OPL;
			S_F_OPL:   state_d = S_F_VX;
			S_F_VX:    state_d = S_F_VY;
			S_F_VY:    state_d = S_EXEC;
			S_EXEC: begin
				case (sts.cls)
					CL_SETF:  state_d = S_SETF;
					CL_CLS:   state_d = S_CLS;
					CL_RET:   state_d = S_RET;
					CL_DRAW:  state_d = S_D_ROW;
					CL_BCD:   state_d = S_BCD0;
					CL_STORE: state_d = S_ST_RD;
					CL_LOAD:  state_d = S_LD_RD;
					default:  state_d = S_TICK;
				endcase
			end
			S_RET:    state_d = S_TICK;
			S_CLS:    if (sts.cls_last) state_d = S_TICK;
			S_SETF:   state_d = S_TICK;
			S_D_ROW:  state_d = sts.row_done ? S_SETF : S_D_BITS;
			S_D_BITS: state_d = S_D_COL;
			S_D_COL: begin
				if (sts.bit_set) begin
					state_d = S_D_PIX;
				end else begin
					state_d = sts.col_last ? S_D_ROW : S_D_COL;
				end
			end
			S_D_PIX:  state_d = sts.col_last ? S_D_ROW : S_D_COL;
			S_BCD0:   state_d = S_BCD1;
			S_BCD1:   state_d = S_BCD2;
			S_BCD2:   state_d = S_TICK;
			S_ST_RD:  state_d = S_ST_WR;
			S_ST_WR:  state_d = sts.idx_last ? S_IEND : S_ST_RD;
			S_LD_RD:  state_d = S_LD_WR;
			S_LD_WR:  state_d = sts.idx_last ? S_IEND : S_LD_RD;
			S_IEND:   state_d = S_TICK;
			S_TICK:   state_d = S_FIN;
			S_FIN:    if (sts.out_free) state_d = S_IDLE;
			default:  state_d = S_SWEEP;
		endcase
	end

	always_comb begin
		case (state_q)
			S_SWEEP:   cmd.uop = U_SWEEP;
			S_IDLE:    cmd.uop = U_IDLE;
			S_LOAD:    cmd.uop = U_LOAD;
			S_PIX_RD:  cmd.uop = U_PIX_RD;
			S_PIX_LAT: cmd.uop = U_PIX_LAT;
			S_F_HI:    cmd.uop = U_F_HI;
			S_F_LO:    cmd.uop = U_F_LO;
			S_F_OPL:   cmd.uop = U_F_OPL;
			S_F_VX:    cmd.uop = U_F_VX;
			S_F_VY:    cmd.uop = U_F_VY;
			S_EXEC:    cmd.uop = U_EXEC;
			S_RET:     cmd.uop = U_RET;
			S_CLS:     cmd.uop = U_CLS;
			S_SETF:    cmd.uop = U_SETF;
			S_D_ROW:   cmd.uop = U_D_ROW;
			S_D_BITS:  cmd.uop = U_D_BITS;
			S_D_COL:   cmd.uop = U_D_COL;
			S_D_PIX:   cmd.uop = U_D_PIX;
			S_BCD0:    cmd.uop = U_BCD0;
			S_BCD1:    cmd.uop = U_BCD1;
			S_BCD2:    cmd.uop = U_BCD2;
			S_ST_RD:   cmd.uop = U_ST_RD;
			S_ST_WR:   cmd.uop = U_ST_WR;
			S_LD_RD:   cmd.uop = U_LD_RD;
			S_LD_WR:   cmd.uop = U_LD_WR;
			S_IEND:    cmd.uop = U_IEND;
			S_TICK:    cmd.uop = U_TICK;
			S_FIN:     cmd.uop = U_FIN;
			default:   cmd.uop = U_SWEEP;
		endcase
	end

	`C8_ASSERT(a_accept_idle, sts.accept |-> state_q == S_IDLE, "item accepted outside idle")
	`C8_ASSERT(a_sweep_once, state_q != S_SWEEP |=> state_q != S_SWEEP, "sweep re-entered")
	`C8_ASSERT(a_exec_after_fetch, state_q == S_EXEC |-> $past(state_q) == S_F_VY, "bad exec entry")
endmodule

[design/c8_dp.sv]
// ----------------------------------------------------------------------------
// c8_dp
// Datapath of the CHIP-8 core: architectural registers, memories, decode and
// the result register.
// ----------------------------------------------------------------------------
module c8_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [11:0]     cfg_wdata,
	input  c8_pkg::cmd_t    cmd,
	output c8_pkg::status_t sts,
	c8_req_if.sink          req,
	c8_rsp_if.source        rsp
);
	import c8_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH);
	localparam logic [SPW-1:0] SP_MAX = SPW'(STACK_DEPTH - 1);

	localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SEI = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4, OP_SER = 4'h5, OP_LDI = 4'h6, OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU = 4'h8, OP_SNER = 4'h9, OP_LDIX = 4'hA, OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND = 4'hC, OP_DRW = 4'hD, OP_KEY = 4'hE;
	localparam logic [15:0] OP_CLS = 16'h00E0, OP_RETN = 16'h00EE;
	localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;
	localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
	localparam logic [7:0] FN_DT_RD = 8'h07, FN_KEYW = 8'h0A, FN_DT_WR = 8'h15;
	localparam logic [7:0] FN_ST_WR = 8'h18, FN_IADD = 8'h1E, FN_FONT = 8'h29;
	localparam logic [7:0] FN_BCD = 8'h33, FN_STORE = 8'h55, FN_LOAD = 8'h65;

	uop_t uop;
	assign uop = cmd.uop;

	// Captured request fields.
	logic [1:0]  act_q;
	logic [11:0] adr_q;
	logic [7:0]  dat_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;

	logic [11:0]    pc_q;
	logic [15:0]    i_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]     dt_q, st_q;
	logic [11:0]    cnt_q;
	logic [15:0]    op_q;
	logic [7:0]     vx_q, vy_q, bits_q;
	logic           f_q;
	logic [3:0]     row_q;
	logic [2:0]     col_q;
	logic [6:0]     bcd_q;
	logic           pixel_q, redraw_q, beep_q, wait_q, unk_q;
	logic           out_valid_q;

	// Memory ports.
	logic              m_we, d_we, d_wd, d_rd, r_we, s_we;
	logic [MEM_AW-1:0] m_wa, m_ra;
	logic [7:0]        m_wd, m_rd, r_wd, r_rd;
	logic [DISP_AW-1:0] d_wa, d_ra;
	logic [3:0]        r_wa, r_ra;
	logic [SPW-1:0]    s_wa;
	logic [11:0]       s_wd, s_rd;

	logic [3:0]  x, y, n;
	logic [7:0]  nn;
	logic [11:0] nnn, pc_next, pc_skip, i_row, i_cnt;
	logic [SPW-1:0] sp_inc, sp_dec;
	logic [DISP_AW-1:0] pix_p;
	logic [4:0]  pix_row;
	logic out_free;

	assign x = op_q[11:8];
	assign y = op_q[7:4];
	assign n = op_q[3:0];
	assign nn = op_q[7:0];
	assign nnn = op_q[11:0];
	assign pc_next = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;
	assign i_row = i_q[11:0] + 12'(row_q);
	assign i_cnt = i_q[11:0] + 12'(cnt_q[3:0]);
	assign sp_inc = (sp_q == SP_MAX) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SP_MAX : sp_q - 1'b1;
	assign pix_row = vy_q[4:0] + 5'(row_q);
	assign pix_p = 11'(vx_q) + 11'(col_q) + {pix_row, 6'd0};

	// Digit extraction: reciprocal multiply, correct over the whole input range.
	logic [13:0] hund_p;
	logic [1:0]  hund;
	logic [7:0]  hund_sub;
	logic [14:0] tens_p;
	logic [3:0]  tens;
	assign hund_p = 14'(vx_q) * 14'd41;
	assign hund = hund_p[13:12];
	always_comb begin
		case (hund)
			2'd1:    hund_sub = 8'd100;
			2'd2:    hund_sub = 8'd200;
			default: hund_sub = 8'd0;
		endcase
	end
	assign tens_p = 15'(bcd_q) * 15'd205;
	assign tens = tens_p[14:11];

	// Instruction decode.
	cls_t        cls;
	logic        unk, vx_we, f_val, i_we, push, redraw, waiting, dt_we, st_we;
	logic [7:0]  vx_val;
	logic [11:0] pc_new;
	logic [15:0] i_val;
	logic [8:0]  alu_sum;
	logic [16:0] i_sum;
	logic        down;

	always_comb begin
		cls = CL_DONE;
		unk = 1'b0;
		vx_we = 1'b0;
		vx_val = '0;
		f_val = 1'b0;
		i_we = 1'b0;
		i_val = i_q;
		push = 1'b0;
		redraw = 1'b0;
		waiting = 1'b0;
		dt_we = 1'b0;
		st_we = 1'b0;
		pc_new = pc_q;
		alu_sum = {1'b0, vx_q} + {1'b0, vy_q};
		i_sum = {1'b0, i_q} + 17'(vx_q);
		down = keys_q[vx_q[3:0]];
		case (op_q[15:12])
			OP_SYS: begin
				if (op_q == OP_CLS) begin
					cls = CL_CLS;
					redraw = 1'b1;
					pc_new = pc_next;
				end else if (op_q == OP_RETN) begin
					cls = CL_RET;
				end else begin
					unk = 1'b1;
				end
			end
			OP_JP: pc_new = nnn;
			OP_CALL: begin
				push = 1'b1;
				pc_new = nnn;
			end
			OP_SEI:  pc_new = (vx_q == nn) ? pc_skip : pc_next;
			OP_SNEI: pc_new = (vx_q != nn) ? pc_skip : pc_next;
			OP_SER:  pc_new = (vx_q == vy_q) ? pc_skip : pc_next;
			OP_SNER: pc_new = (vx_q != vy_q) ? pc_skip : pc_next;
			OP_LDI: begin
				vx_we = 1'b1;
				vx_val = nn;
				pc_new = pc_next;
			end
			OP_ADDI: begin
				vx_we = 1'b1;
				vx_val = vx_q + nn;
				pc_new = pc_next;
			end
			OP_ALU: begin
				vx_we = 1'b1;
				pc_new = pc_next;
				case (n)
					ALU_MOV: vx_val = vy_q;
					ALU_OR:  vx_val = vx_q | vy_q;
					ALU_AND: vx_val = vx_q & vy_q;
					ALU_XOR: vx_val = vx_q ^ vy_q;
					ALU_ADD: begin
						vx_val = alu_sum[7:0];
						f_val = alu_sum[8];
						cls = CL_SETF;
					end
					ALU_SUB: begin
						vx_val = vx_q - vy_q;
						f_val = (vx_q >= vy_q);
						cls = CL_SETF;
					end
					ALU_SHR: begin
						vx_val = {1'b0, vx_q[7:1]};
						f_val = vx_q[0];
						cls = CL_SETF;
					end
					ALU_SUBN: begin
						vx_val = vy_q - vx_q;
						f_val = (vy_q >= vx_q);
						cls = CL_SETF;
					end
					ALU_SHL: begin
						vx_val = {vx_q[6:0], 1'b0};
						f_val = vx_q[7];
						cls = CL_SETF;
					end
					default: begin
						unk = 1'b1;
						vx_we = 1'b0;
						pc_new = pc_q;
					end
				endcase
			end
			OP_LDIX: begin
				i_we = 1'b1;
				i_val = {4'd0, nnn};
				pc_new = pc_next;
			end
			// The Y read slot fetched V0 for this opcode.
			OP_JPV0: pc_new = nnn + 12'(vy_q);
			OP_RND: begin
				vx_we = 1'b1;
				vx_val = rnd_q & nn;
				pc_new = pc_next;
			end
			OP_DRW: begin
				cls = CL_DRAW;
				redraw = 1'b1;
				pc_new = pc_next;
			end
			OP_KEY: begin
				case (nn)
					KEY_DOWN: pc_new = down ? pc_skip : pc_next;
					KEY_UP:   pc_new = down ? pc_next : pc_skip;
					default:  unk = 1'b1;
				endcase
			end
			default: begin
				case (nn)
					FN_DT_RD: begin
						vx_we = 1'b1;
						vx_val = dt_q;
						pc_new = pc_next;
					end
					FN_KEYW: begin
						if (keys_q == '0) begin
							waiting = 1'b1;
						end else begin
							vx_we = 1'b1;
							vx_val = 8'(high_key(keys_q));
							pc_new = pc_next;
						end
					end
					FN_DT_WR: begin
						dt_we = 1'b1;
						pc_new = pc_next;
					end
					FN_ST_WR: begin
						st_we = 1'b1;
						pc_new = pc_next;
					end
					FN_IADD: begin
						i_we = 1'b1;
						i_val = i_sum[15:0];
						f_val = (i_sum[16:12] != '0);
						cls = CL_SETF;
						pc_new = pc_next;
					end
					FN_FONT: begin
						i_we = 1'b1;
						i_val = {6'd0, vx_q, 2'd0} + 16'(vx_q);
						pc_new = pc_next;
					end
					FN_BCD: begin
						cls = CL_BCD;
						pc_new = pc_next;
					end
					FN_STORE: begin
						cls = CL_STORE;
						pc_new = pc_next;
					end
					FN_LOAD: begin
						cls = CL_LOAD;
						pc_new = pc_next;
					end
					default: unk = 1'b1;
				endcase
			end
		endcase
	end

	// Memory port selection.
	always_comb begin
		m_we = 1'b0;
		m_wa = i_cnt;
		m_wd = r_rd;
		m_ra = pc_q;
		d_we = 1'b0;
		d_wa = pix_p;
		d_wd = 1'b0;
		d_ra = pix_p;
		r_we = 1'b0;
		r_wa = x;
		r_wd = vx_val;
		r_ra = x;
		s_we = 1'b0;
		s_wa = sp_q;
		s_wd = pc_q;
		case (uop)
			U_SWEEP: begin
				m_we = 1'b1;
				m_wa = cnt_q;
				m_wd = (cnt_q < 12'(FONT_BYTES)) ? FONT[cnt_q[6:0]] : 8'd0;
				d_we = 1'b1;
				d_wa = cnt_q[DISP_AW-1:0];
				r_we = 1'b1;
				r_wa = cnt_q[3:0];
				r_wd = 8'd0;
				s_we = 1'b1;
				s_wa = cnt_q[SPW-1:0];
				s_wd = 12'd0;
			end
			U_LOAD: begin
				m_we = 1'b1;
				m_wa = adr_q;
				m_wd = dat_q;
			end
			U_PIX_RD: d_ra = adr_q[DISP_AW-1:0];
			U_F_LO:   m_ra = pc_q + 12'd1;
			U_F_VX:   r_ra = (op_q[15:12] == OP_JPV0) ? 4'd0 : y;
			U_EXEC: begin
				r_we = vx_we;
				s_we = push;
			end
			U_CLS: begin
				d_we = 1'b1;
				d_wa = cnt_q[DISP_AW-1:0];
			end
			U_SETF: begin
				r_we = 1'b1;
				r_wa = 4'hF;
				r_wd = {7'd0, f_q};
			end
			U_D_ROW: m_ra = i_row;
			U_D_PIX: begin
				d_we = 1'b1;
				d_wd = ~d_rd;
			end
			U_BCD0: begin
				m_we = 1'b1;
				m_wa = i_q[11:0];
				m_wd = 8'(hund);
			end
			U_BCD1: begin
				m_we = 1'b1;
				m_wa = i_q[11:0] + 12'd1;
				m_wd = 8'(tens);
			end
			U_BCD2: begin
				m_we = 1'b1;
				m_wa = i_q[11:0] + 12'd2;
				m_wd = 8'(bcd_q);
			end
			U_ST_RD: r_ra = cnt_q[3:0];
			U_ST_WR: m_we = 1'b1;
			U_LD_RD: m_ra = i_cnt;
			U_LD_WR: begin
				r_we = 1'b1;
				r_wa = cnt_q[3:0];
				r_wd = m_rd;
			end
			default: begin
			end
		endcase
	end

	c8_ram #(.W(8), .D(MEM_BYTES)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
	);
	c8_ram #(.W(1), .D(DISP_PIXELS)) u_disp (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
	);
	c8_ram #(.W(8), .D(16)) u_regs (
		.clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
	);
	c8_ram #(.W(12), .D(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(sp_dec), .rdata(s_rd)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (uop == U_IDLE);

	always_comb begin
		sts.accept = req.valid && req.ready;
		sts.action = req.action;
		sts.cls = cls;
		sts.row_done = (row_q == n);
		sts.bit_set = bits_q[3'd7 - col_q];
		sts.col_last = (col_q == 3'd7);
		sts.idx_last = (cnt_q[3:0] == x);
		sts.cls_last = &cnt_q[DISP_AW-1:0];
		sts.sweep_last = &cnt_q;
		sts.out_free = out_free;
	end

	// Architectural and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= START_RESET;
			i_q <= '0;
			sp_q <= '0;
			dt_q <= '0;
			st_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			// A new result may replace one that is taken in the same cycle.
			if (uop == U_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (uop)
				U_SWEEP, U_CLS, U_ST_WR, U_LD_WR: cnt_q <= cnt_q + 12'd1;
				U_EXEC: begin
					pc_q <= pc_new;
					cnt_q <= '0;
					if (i_we) i_q <= i_val;
					if (push) sp_q <= sp_inc;
					if (cls == CL_RET) sp_q <= sp_dec;
					if (dt_we) dt_q <= vx_q;
					if (st_we) st_q <= vx_q;
				end
				U_RET:  pc_q <= s_rd + 12'd2;
				U_IEND: i_q <= i_q + 16'(x) + 16'd1;
				U_TICK: begin
					if (dt_q != '0) dt_q <= dt_q - 8'd1;
					if (st_q != '0) st_q <= st_q - 8'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (uop)
			U_IDLE: begin
				if (req.valid) begin
					act_q <= req.action;
					adr_q <= req.address;
					dat_q <= req.data;
					keys_q <= req.keys;
					rnd_q <= req.random_byte;
					op_q <= '0;
					pixel_q <= 1'b0;
					redraw_q <= 1'b0;
					beep_q <= 1'b0;
					wait_q <= 1'b0;
					unk_q <= 1'b0;
				end
			end
			U_PIX_LAT: pixel_q <= d_rd;
			U_F_LO:    op_q[15:8] <= m_rd;
			U_F_OPL:   op_q[7:0] <= m_rd;
			U_F_VX:    vx_q <= r_rd;
			U_F_VY:    vy_q <= r_rd;
			U_EXEC: begin
				f_q <= f_val;
				redraw_q <= redraw;
				wait_q <= waiting;
				unk_q <= unk;
				row_q <= '0;
			end
			U_D_BITS: begin
				bits_q <= m_rd;
				col_q <= '0;
			end
			U_D_COL: begin
				if (!sts.bit_set) begin
					col_q <= col_q + 3'd1;
					if (sts.col_last) row_q <= row_q + 4'd1;
				end
			end
			U_D_PIX: begin
				f_q <= f_q | d_rd;
				col_q <= col_q + 3'd1;
				if (sts.col_last) row_q <= row_q + 4'd1;
			end
			U_BCD0: bcd_q <= 7'(vx_q - hund_sub);
			U_BCD1: bcd_q <= bcd_q - 7'({tens, 3'd0} + {tens, 1'd0});
			U_TICK: beep_q <= (st_q == 8'd1);
			U_FIN: begin
				if (out_free) begin
					rsp.program_counter <= pc_q;
					rsp.executed_opcode <= (act_q == ACT_EXEC) ? op_q : 16'd0;
					rsp.pixel <= pixel_q;
					rsp.redraw <= redraw_q;
					rsp.beep <= beep_q;
					rsp.waiting_key <= wait_q;
					rsp.unknown_opcode <= unk_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
endmodule

[design/chip8_instruction_step_unit.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_step_unit
// CHIP-8 processor core stepped one item at a time.
// ----------------------------------------------------------------------------
// Each request item loads a memory byte, executes one instruction and ticks
// the timers, or reads a display pixel, and gives one result item. After
// reset the core sweeps its memories (font preset, display, registers and
// stack cleared) before it accepts the first item. An instruction fetches
// its two opcode bytes and reads its two operand registers, executes, writes
// VF where the opcode sets it and ticks the timers; BCD writes its digits one
// after another. Screen clear walks the display at one pixel a cycle. A sprite
// draw reads each sprite row and walks its columns, with an extra step per
// set sprite bit. Register block moves read and write one register at a time.
// All of this comes from the single read and write port of each memory. The
// result waits in an output register, so the next item is taken while it is
// still held.
module chip8_instruction_step_unit #(
	parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	c8_req_if.sink      req,
	c8_rsp_if.source    rsp
);
	import c8_pkg::*;

	cmd_t    cmd;
	status_t sts;

	c8_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	c8_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd(cmd), .sts(sts), .req(req), .rsp(rsp)
	);
endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CHIP-8 instruction step unit.
// ----------------------------------------------------------------------------
// Every request item is mirrored in a behavioral copy of the core that is
// kept inside the bench. Each request item gives one expected result item,
// and the result items are compared in order. Directed tests cover the
// corner cases first. Random programs then follow, with most instructions
// written at the predicted program counter just before they run. Both
// channels idle and stall at random, apart from one stretch of the random
// phase without gaps, and the start address is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import c8_pkg::*;

	localparam logic [1:0] ACT_PIXEL = 2'd2;
	localparam logic [1:0] ACT_ALIAS = 2'd3;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	typedef enum logic [3:0] {
		GRP_SYS, GRP_JUMP, GRP_CALL, GRP_SKEQ_IMM, GRP_SKNE_IMM, GRP_SKEQ_REG,
		GRP_SET_IMM, GRP_ADD_IMM, GRP_ALU, GRP_SKNE_REG, GRP_SET_I, GRP_JUMP_V0,
		GRP_RAND, GRP_DRAW, GRP_KEY, GRP_MISC
	} op_grp_e;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	localparam logic [7:0] MISC_GET_DELAY = 8'h07;
	localparam logic [7:0] MISC_WAIT_KEY  = 8'h0A;
	localparam logic [7:0] MISC_SET_DELAY = 8'h15;
	localparam logic [7:0] MISC_SET_SOUND = 8'h18;
	localparam logic [7:0] MISC_ADD_I     = 8'h1E;
	localparam logic [7:0] MISC_GLYPH     = 8'h29;
	localparam logic [7:0] MISC_BCD       = 8'h33;
	localparam logic [7:0] MISC_STORE     = 8'h55;
	localparam logic [7:0] MISC_LOAD      = 8'h65;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 1500;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] address;
		logic [7:0]  data;
		logic [15:0] keys;
		logic [7:0]  random_byte;
	} step_req_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] executed_opcode;
		logic        pixel;
		logic        redraw;
		logic        beep;
		logic        waiting_key;
		logic        unknown_opcode;
	} step_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [11:0] cfg_wdata;

	c8_req_if req ();
	c8_rsp_if rsp ();

	chip8_instruction_step_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	// Shadow copy of the core state.
	logic [7:0]  mem_q [MEM_BYTES];
	logic        disp_q [DISP_PIXELS];
	logic [7:0]  v_q [16];
	logic [15:0] i_q;
	logic [11:0] pc_q;
	logic [11:0] stack_q [16];
	logic [3:0]  sp_q;
	logic [7:0]  delay_q;
	logic [7:0]  sound_q;

	step_rsp_t expected_results [$];
	int errors;
	int cycles;
	int n_exec, n_draw, n_clear, n_beep, n_wait, n_unknown, n_reads;
	bit gaps_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("chip8_instruction_step_unit test failed");
				$finish;
			end
		end
	end

	// Works out one result item and updates the shadow state.
	task automatic predict_step(input step_req_t it, output step_rsp_t r);
		logic [11:0] pc, nxt, skp;
		logic [15:0] op;
		logic [3:0] x, y, n;
		logic [7:0] nn, vx, vy, res, fl, bits;
		logic [8:0] wide;
		logic [16:0] sum;
		logic [10:0] p;
		logic setf, hit, down;
		int row, col, k;
		r = '0;
		case (it.action)
			ACT_LOAD: mem_q[it.address] = it.data;
			ACT_EXEC: begin
				pc = pc_q;
				nxt = pc + 12'd2;
				skp = pc + 12'd4;
				op = {mem_q[pc], mem_q[pc + 12'd1]};
				x = op[11:8];
				y = op[7:4];
				n = op[3:0];
				nn = op[7:0];
				vx = v_q[x];
				vy = v_q[y];
				n_exec++;
				case (op_grp_e'(op[15:12]))
					GRP_SYS: begin
						if (op == OP_CLS) begin
							for (k = 0; k < DISP_PIXELS; k++) disp_q[k] = 1'b0;
							r.redraw = 1'b1;
							n_clear++;
							pc = nxt;
						end else if (op == OP_RET) begin
							sp_q = sp_q - 4'd1;
							pc = stack_q[sp_q] + 12'd2;
						end else begin
							r.unknown_opcode = 1'b1;
						end
					end
					GRP_JUMP: pc = op[11:0];
					GRP_CALL: begin
						stack_q[sp_q] = pc;
						sp_q = sp_q + 4'd1;
						pc = op[11:0];
					end
					GRP_SKEQ_IMM: pc = (vx == nn) ? skp : nxt;
					GRP_SKNE_IMM: pc = (vx != nn) ? skp : nxt;
					GRP_SKEQ_REG: pc = (vx == vy) ? skp : nxt;
					GRP_SET_IMM: begin v_q[x] = nn; pc = nxt; end
					GRP_ADD_IMM: begin v_q[x] = vx + nn; pc = nxt; end
					GRP_ALU: begin
						setf = 1'b1;
						fl = '0;
						res = '0;
						case (n)
							ALU_MOV: begin res = vy; setf = 1'b0; end
							ALU_OR:  begin res = vx | vy; setf = 1'b0; end
							ALU_AND: begin res = vx & vy; setf = 1'b0; end
							ALU_XOR: begin res = vx ^ vy; setf = 1'b0; end
							ALU_ADD: begin
								wide = {1'b0, vx} + {1'b0, vy};
								res = wide[7:0];
								fl = {7'd0, wide[8]};
							end
							ALU_SUB: begin res = vx - vy; fl = {7'd0, vx >= vy}; end
							ALU_SHR: begin res = vx >> 1; fl = {7'd0, vx[0]}; end
							ALU_RSB: begin res = vy - vx; fl = {7'd0, vy >= vx}; end
							ALU_SHL: begin res = vx << 1; fl = {7'd0, vx[7]}; end
							default: r.unknown_opcode = 1'b1;
						endcase
						if (!r.unknown_opcode) begin
							// The flag is written after the result register.
							v_q[x] = res;
							if (setf) v_q[15] = fl;
							pc = nxt;
						end
					end
					GRP_SKNE_REG: pc = (vx != vy) ? skp : nxt;
					GRP_SET_I: begin i_q = {4'd0, op[11:0]}; pc = nxt; end
					GRP_JUMP_V0: pc = op[11:0] + {4'd0, v_q[0]};
					GRP_RAND: begin v_q[x] = it.random_byte & nn; pc = nxt; end
					GRP_DRAW: begin
						hit = 1'b0;
						for (row = 0; row < n; row++) begin
							bits = mem_q[12'(i_q + 16'(row))];
							for (col = 0; col < 8; col++) begin
								if (bits[7 - col]) begin
									p = 11'(vx + col + (vy + row) * 64);
									if (disp_q[p]) hit = 1'b1;
									disp_q[p] = ~disp_q[p];
								end
							end
						end
						v_q[15] = {7'd0, hit};
						r.redraw = 1'b1;
						n_draw++;
						pc = nxt;
					end
					GRP_KEY: begin
						down = it.keys[vx[3:0]];
						if (nn == KEY_DOWN) pc = down ? skp : nxt;
						else if (nn == KEY_UP) pc = down ? nxt : skp;
						else r.unknown_opcode = 1'b1;
					end
					default: begin
						case (nn)
							MISC_GET_DELAY: begin v_q[x] = delay_q; pc = nxt; end
							MISC_WAIT_KEY: begin
								if (it.keys == '0) begin
									r.waiting_key = 1'b1;
								end else begin
									for (k = 0; k < 16; k++) if (it.keys[k]) v_q[x] = 8'(k);
									pc = nxt;
								end
							end
							MISC_SET_DELAY: begin delay_q = vx; pc = nxt; end
							MISC_SET_SOUND: begin sound_q = vx; pc = nxt; end
							MISC_ADD_I: begin
								sum = {1'b0, i_q} + {9'd0, vx};
								i_q = sum[15:0];
								v_q[15] = {7'd0, sum > 17'hFFF};
								pc = nxt;
							end
							MISC_GLYPH: begin i_q = 16'(vx) * 16'd5; pc = nxt; end
							MISC_BCD: begin
								mem_q[i_q[11:0]] = vx / 8'd100;
								mem_q[i_q[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
								mem_q[i_q[11:0] + 12'd2] = vx % 8'd10;
								pc = nxt;
							end
							MISC_STORE: begin
								for (k = 0; k <= x; k++) mem_q[12'(i_q + 16'(k))] = v_q[k];
								i_q = i_q + 16'(x) + 16'd1;
								pc = nxt;
							end
							MISC_LOAD: begin
								for (k = 0; k <= x; k++) v_q[k] = mem_q[12'(i_q + 16'(k))];
								i_q = i_q + 16'(x) + 16'd1;
								pc = nxt;
							end
							default: r.unknown_opcode = 1'b1;
						endcase
					end
				endcase
				pc_q = pc;
				if (delay_q != 0) delay_q--;
				if (sound_q != 0) begin
					if (sound_q == 8'd1) begin
						r.beep = 1'b1;
						n_beep++;
					end
					sound_q--;
				end
				r.executed_opcode = op;
				n_wait += r.waiting_key;
				n_unknown += r.unknown_opcode;
			end
			default: begin
				// Action 3 reads a pixel as action 2 does.
				r.pixel = disp_q[it.address[10:0]];
				n_reads++;
			end
		endcase
		r.program_counter = pc_q;
	endtask

	task automatic send_item(input step_req_t it);
		step_rsp_t r;
		if (gaps_on && $urandom_range(99) < 6) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= it.action;
		req.address <= it.address;
		req.data <= it.data;
		req.keys <= it.keys;
		req.random_byte <= it.random_byte;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_step(it, r);
		expected_results.push_back(r);
	endtask

	task automatic load_byte(input logic [11:0] a, input logic [7:0] d);
		step_req_t it;
		it = '{ACT_LOAD, a, d, 16'($urandom), 8'($urandom)};
		send_item(it);
	endtask

	task automatic read_pixel(input logic [11:0] a, input logic [1:0] act);
		step_req_t it;
		it = '{act, a, 8'($urandom), 16'($urandom), 8'($urandom)};
		send_item(it);
	endtask

	task automatic execute(input logic [15:0] keys, input logic [7:0] rnd);
		step_req_t it;
		it = '{ACT_EXEC, 12'($urandom), 8'($urandom), keys, rnd};
		send_item(it);
	endtask

	// Places one instruction at the predicted program counter and runs it.
	task automatic run_op(input logic [15:0] op, input logic [15:0] keys,
			input logic [7:0] rnd);
		load_byte(pc_q, op[15:8]);
		load_byte(pc_q + 12'd1, op[7:0]);
		execute(keys, rnd);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_start(input logic [11:0] a);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		pc_q = a;
	endtask

	function automatic logic [15:0] random_keys();
		case ($urandom_range(3))
			0: return '0;
			1: return 16'd1 << $urandom_range(15);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] random_opcode();
		logic [15:0] op;
		logic [7:0] misc [9];
		op = 16'($urandom);
		misc = '{MISC_GET_DELAY, MISC_WAIT_KEY, MISC_SET_DELAY, MISC_SET_SOUND,
			MISC_ADD_I, MISC_GLYPH, MISC_BCD, MISC_STORE, MISC_LOAD};
		case (op_grp_e'(op[15:12]))
			GRP_SYS: begin
				// Screen clear is slow, so it is kept rare.
				if ($urandom_range(99) < 20) op = OP_CLS;
				else if ($urandom_range(99) < 60) op = OP_RET;
			end
			GRP_ALU: if ($urandom_range(9) != 0)
				op[3:0] = (op[3] && op[3:0] != ALU_SHL) ? ALU_SHL : op[3:0];
			GRP_KEY: if ($urandom_range(9) != 0)
				op[7:0] = op[0] ? KEY_DOWN : KEY_UP;
			GRP_MISC: if ($urandom_range(9) != 0) op[7:0] = misc[$urandom_range(8)];
			default: ;
		endcase
		return op;
	endfunction

	task automatic test_reset_state();
		read_pixel(12'd0, ACT_PIXEL);
		read_pixel(12'hFFF, ACT_ALIAS);
		// Empty memory at the start address decodes as an unknown opcode.
		execute('0, '0);
	endtask

	task automatic test_register_ops();
		run_op({GRP_SET_IMM, 4'hF, 8'hFF}, '0, '0);
		run_op({GRP_ALU, 4'hF, 4'hF, ALU_ADD}, '0, '0);
		run_op({GRP_MISC, 4'h0, MISC_WAIT_KEY}, '0, '0);
		run_op({GRP_MISC, 4'h3, MISC_WAIT_KEY}, 16'h8421, '0);
		run_op({GRP_RAND, 4'h2, 8'hFF}, '0, 8'hFF);
		run_op(OP_RET, 16'hFFFF, 8'h00);
	endtask

	task automatic test_start_address();
		write_start(12'hFFF);
		run_op({GRP_SET_I, 12'hFFE}, '0, '0);
		write_start(12'h000);
		execute(16'hFFFF, 8'hFF);
		write_start(START_RESET);
	endtask

	task automatic test_random_programs();
		int k;
		int j;
		for (k = 0; k < RANDOM_ITEMS; ) begin
			if (k == 500) write_start(12'($urandom));
			if (k == 1000) write_start(START_RESET);
			gaps_on = !(k >= 600 && k < 900);
			case ($urandom_range(19))
				0: begin load_byte(12'($urandom), 8'($urandom)); k++; end
				1: begin execute(random_keys(), 8'($urandom)); k++; end
				2, 3: begin
					for (j = 0; j < 4; j++) read_pixel(12'($urandom), 2'($urandom_range(2, 3)));
					k += 4;
				end
				default: begin
					run_op(random_opcode(), random_keys(), 8'($urandom));
					k += 3;
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		rsp.ready <= (gaps_on && $urandom_range(99) < 6) ? 1'b0 : 1'b1;
	end

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		step_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("result item with no request outstanding");
				errors++;
			end else begin
				e = expected_results.pop_front();
				check_field("program_counter", e.program_counter, rsp.program_counter);
				check_field("executed_opcode", e.executed_opcode, rsp.executed_opcode);
				check_field("pixel", e.pixel, rsp.pixel);
				check_field("redraw", e.redraw, rsp.redraw);
				check_field("beep", e.beep, rsp.beep);
				check_field("waiting_key", e.waiting_key, rsp.waiting_key);
				check_field("unknown_opcode", e.unknown_opcode, rsp.unknown_opcode);
			end
		end
	end

	initial begin
		int k;
		errors = 0;
		{n_exec, n_draw, n_clear, n_beep, n_wait, n_unknown, n_reads} = '0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.action = '0;
		req.address = '0;
		req.data = '0;
		req.keys = '0;
		req.random_byte = '0;
		rsp.ready = 1'b0;
		for (k = 0; k < MEM_BYTES; k++) mem_q[k] = (k < FONT_BYTES) ? FONT[k] : 8'h00;
		for (k = 0; k < DISP_PIXELS; k++) disp_q[k] = 1'b0;
		for (k = 0; k < 16; k++) begin
			v_q[k] = '0;
			stack_q[k] = '0;
		end
		i_q = '0;
		pc_q = START_RESET;
		sp_q = '0;
		delay_q = '0;
		sound_q = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_ops();
		test_start_address();
		test_random_programs();

		drain_results();
		$display("Ran %0d instructions: %0d sprite draws, %0d screen clears, %0d beeps,",
			n_exec, n_draw, n_clear, n_beep);
		$display("%0d key waits, %0d unknown opcodes and %0d pixel reads.",
			n_wait, n_unknown, n_reads);
		if (errors == 0) begin
			$display("chip8_instruction_step_unit test passed");
		end else begin
			$display("chip8_instruction_step_unit test failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/c8_pkg.sv
design/c8_if.sv
design/c8_ram.sv
design/c8_ctrl.sv
design/c8_dp.sv
design/chip8_instruction_step_unit.sv
bench/tb_top.sv
